[src/krm_pkg.sv]
// ----------------------------------------------------------------------------
// krm_pkg: shared types and constants of the knock rhythm matcher
// Field widths, register codes, tick phases and the controller command and
// status groups.
// ----------------------------------------------------------------------------
package krm_pkg;

	localparam int SAMPLE_W   = 16;      // signed converter reading
	localparam int THR_W      = 15;      // knock threshold
	localparam int WAIT_W     = 16;      // debounce and open hold counts
	localparam int TOL_W      = 7;       // tolerance in percent
	localparam int DES_W      = 24;      // desired interval
	localparam int DES_CNT    = 4;       // desired interval registers
	localparam int DES_IDX_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_W      = 8;       // result word, zero padded

	// normalized entries are at most 10000, so 14 quotient bits
	localparam int NORM_W = 14;
	localparam logic [NORM_W-1:0] NORM_SCALE = 14'd10000;

	// tolerance check: 100*m, 100*d and d*tol all stay below 2^22
	localparam int CHECK_W = 22;
	localparam logic [6:0] PERCENT = 7'd100;

	localparam logic [THR_W-1:0]  THR_RESET  = 15'd600;
	localparam logic [WAIT_W-1:0] DEB_RESET  = 16'd50;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd60;
	localparam logic [WAIT_W-1:0] HOLD_RESET = 16'd500;
	localparam logic [DES_W-1:0]  DES_RESET  = 24'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_DEBOUNCE  = 3'd1,
		CFG_TOLERANCE = 3'd2,
		CFG_OPEN_HOLD = 3'd3,
		CFG_DESIRED_0 = 3'd4,
		CFG_DESIRED_1 = 3'd5,
		CFG_DESIRED_2 = 3'd6,
		CFG_DESIRED_3 = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TIMING = 2'd1,
		PH_OPEN   = 2'd2
	} phase_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // input word taken this edge
		logic tick;       // apply one tick to the knock state
		logic sum;        // accumulate entry idx into both sums
		logic div_d;      // start desired entry normalization
		logic div_m;      // keep desired quotient, start measured one
		logic check;      // tolerance check of entry idx
		logic fin;        // apply match outcome
		logic out_load;   // write result register
	} krm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // result register free at this edge
		logic complete;   // tick closes a pattern
		logic sum_zero;   // a sum is zero, no match
		logic div_busy;
	} krm_sts_t;

endpackage

[src/krm_div.sv]
// ----------------------------------------------------------------------------
// krm_div: restoring divider for the normalizing step
// One quotient bit per cycle; the quotient is known to fit in NORM_W bits.
// ----------------------------------------------------------------------------
module krm_div
	import krm_pkg::*;
#(
	parameter int NUM_W = 38,
	parameter int DEN_W = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              busy,
	output logic [NORM_W-1:0] quo
);

	localparam int CMP_W = DEN_W + NORM_W;
	localparam int CNT_W = $clog2(NORM_W);

	logic [NUM_W-1:0]  rem_q;
	logic [CMP_W-1:0]  dsh_q;
	logic [NORM_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              ge;

	assign ge = CMP_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NORM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= CMP_W'(den) << (NORM_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[NORM_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

[src/krm_dp.sv]
// ----------------------------------------------------------------------------
// krm_dp: datapath of the knock rhythm matcher
// Config registers, knock timing state, interval store, pattern sums,
// divider, tolerance check and the result register.
// ----------------------------------------------------------------------------
module krm_dp
	import krm_pkg::*;
#(
	parameter int PATTERN_LEN = 2,
	parameter int INTERVAL_BITS = 24,
	localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SAMPLE_W-1:0]   s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  krm_cmd_t              cmd,
	input  logic [IDX_W-1:0]      idx,
	output krm_sts_t              sts
);

	localparam int VAL_W = (INTERVAL_BITS > DES_W) ? INTERVAL_BITS : DES_W;
	localparam int SUM_W = VAL_W + $clog2(PATTERN_LEN);
	localparam int NUM_W = VAL_W + NORM_W;

	// configuration
	logic [THR_W-1:0]  thr_q;
	logic [WAIT_W-1:0] deb_q;
	logic [TOL_W-1:0]  tol_q;
	logic [WAIT_W-1:0] hold_q;
	logic [DES_W-1:0]  des_q [DES_CNT];

	// knock state
	logic [SAMPLE_W-1:0]      sample_q;
	phase_t                   phase_q, phase_n;
	logic [IDX_W-1:0]         kc_q, kc_n;
	logic [INTERVAL_BITS-1:0] gap_q, gap_n, gap_inc;
	logic [WAIT_W-1:0]        wait_q, wait_n;
	logic [INTERVAL_BITS-1:0] store_q [PATTERN_LEN];
	logic                     store_we;
	logic                     knock;
	logic                     complete;

	// match evaluation
	logic [SUM_W-1:0]  dsum_q, msum_q;
	logic [NORM_W-1:0] d_q, quo;
	logic              ok_q, div_busy, match, pass;
	logic [VAL_W-1:0]  des_val, int_val;
	logic [NUM_W-1:0]  div_num;
	logic [CHECK_W-1:0] d100, m100, dev;

	// result register
	logic out_full_q, lock_q, done_q, match_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			deb_q  <= DEB_RESET;
			tol_q  <= TOL_RESET;
			hold_q <= HOLD_RESET;
			for (int i = 0; i < DES_CNT; i++) begin
				des_q[i] <= DES_RESET;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				CFG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				CFG_DEBOUNCE:  deb_q  <= cfg_data[WAIT_W-1:0];
				CFG_TOLERANCE: tol_q  <= cfg_data[TOL_W-1:0];
				CFG_OPEN_HOLD: hold_q <= cfg_data[WAIT_W-1:0];
				CFG_DESIRED_0, CFG_DESIRED_1, CFG_DESIRED_2, CFG_DESIRED_3: begin
					des_q[cfg_index[DES_IDX_W-1:0]] <= cfg_data[DES_W-1:0];
				end
			endcase
		end
	end

	// ---- one tick of knock timing ----
	assign knock   = $signed(sample_q) >= $signed({1'b0, thr_q});
	assign gap_inc = (phase_q == PH_TIMING && gap_q != {INTERVAL_BITS{1'b1}}) ?
		gap_q + 1'b1 : gap_q;

	always_comb begin
		phase_n  = phase_q;
		kc_n     = kc_q;
		gap_n    = gap_inc;
		wait_n   = wait_q;
		store_we = 1'b0;
		complete = 1'b0;
		if (wait_q != '0) begin
			wait_n = wait_q - 1'b1;
			if (wait_q == WAIT_W'(1) && phase_q == PH_OPEN) begin
				phase_n = PH_IDLE;
			end
		end else if (knock) begin
			gap_n  = '0;
			wait_n = deb_q;
			if (phase_q == PH_TIMING) begin
				store_we = 1'b1;
				if (kc_q == IDX_W'(PATTERN_LEN - 1)) begin
					// last gap: outcome applied after the match check
					complete = 1'b1;
					kc_n     = '0;
					phase_n  = PH_IDLE;
				end else begin
					kc_n = kc_q + 1'b1;
				end
			end else begin
				phase_n = PH_TIMING;
				kc_n    = '0;
			end
		end
	end

	assign sts.complete = complete;

	assign match = ok_q && !sts.sum_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kc_q    <= '0;
			gap_q   <= '0;
			wait_q  <= '0;
		end else if (cmd.tick) begin
			phase_q <= phase_n;
			kc_q    <= kc_n;
			gap_q   <= gap_n;
			wait_q  <= wait_n;
		end else if (cmd.fin && match) begin
			if (hold_q != '0) begin
				phase_q <= PH_OPEN;
				wait_q  <= hold_q;
			end else begin
				wait_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= s_tdata;
		end
		if (cmd.tick && store_we) begin
			store_q[kc_q] <= gap_inc;
		end
	end

	// ---- match evaluation ----
	assign des_val = VAL_W'(des_q[DES_IDX_W'(idx)]);
	assign int_val = VAL_W'(store_q[idx]);
	assign sts.sum_zero = (dsum_q == '0) || (msum_q == '0);

	assign div_num = (cmd.div_m ? NUM_W'(int_val) : NUM_W'(des_val)) * NUM_W'(NORM_SCALE);

	krm_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_d | cmd.div_m),
		.num    (div_num),
		.den    (cmd.div_m ? msum_q : dsum_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	assign sts.div_busy = div_busy;

	// lower bound: 100*m + d*tol >= 100*d; upper: 100*m <= 100*d + d*tol
	assign d100 = CHECK_W'(d_q) * CHECK_W'(PERCENT);
	assign m100 = CHECK_W'(quo) * CHECK_W'(PERCENT);
	assign dev  = CHECK_W'(d_q) * CHECK_W'(tol_q);
	assign pass = (m100 + dev >= d100) && (m100 <= d100 + dev);

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			if (idx == '0) begin
				dsum_q <= SUM_W'(des_val);
				msum_q <= SUM_W'(int_val);
				ok_q   <= 1'b1;
			end else begin
				dsum_q <= dsum_q + SUM_W'(des_val);
				msum_q <= msum_q + SUM_W'(int_val);
			end
		end
		if (cmd.div_m) begin
			d_q <= quo;
		end
		if (cmd.check && !pass) begin
			ok_q <= 1'b0;
		end
	end

	// ---- result register ----
	assign sts.out_free = !out_full_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (m_tready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.fin) begin
				lock_q  <= match && (hold_q != '0);
				done_q  <= 1'b1;
				match_q <= match;
			end else begin
				lock_q  <= (phase_n == PH_OPEN);
				done_q  <= 1'b0;
				match_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = {{(OUT_W - 3){1'b0}}, match_q, done_q, lock_q};

endmodule

[src/krm_ctrl.sv]
// ----------------------------------------------------------------------------
// krm_ctrl: sequencer of the knock rhythm matcher
// Takes a sample, runs its tick, and at pattern end walks the entries
// through sums, two divisions each and the tolerance check.
// ----------------------------------------------------------------------------
module krm_ctrl
	import krm_pkg::*;
#(
	parameter int PATTERN_LEN = 2,
	localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  krm_sts_t         sts,
	output krm_cmd_t         cmd,
	output logic [IDX_W-1:0] idx
);

	typedef enum logic [3:0] {
		ST_IN,
		ST_TICK,
		ST_SUM,
		ST_DIV_D,
		ST_WAIT_D,
		ST_DIV_M,
		ST_WAIT_M,
		ST_CHECK,
		ST_FIN
	} state_t;

	state_t           state_q, state_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic             last;

	assign last = idx_q == IDX_W'(PATTERN_LEN - 1);

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IN: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_n = ST_TICK;
				end
			end
			ST_TICK: begin
				if (sts.out_free) begin
					cmd.tick = 1'b1;
					if (sts.complete) begin
						idx_n   = '0;
						state_n = ST_SUM;
					end else begin
						cmd.out_load = 1'b1;
						state_n      = ST_IN;
					end
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (last) begin
					idx_n   = '0;
					state_n = ST_DIV_D;
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			ST_DIV_D: begin
				if (sts.sum_zero) begin
					state_n = ST_FIN;
				end else begin
					cmd.div_d = 1'b1;
					state_n   = ST_WAIT_D;
				end
			end
			ST_WAIT_D: begin
				if (!sts.div_busy) begin
					state_n = ST_DIV_M;
				end
			end
			ST_DIV_M: begin
				cmd.div_m = 1'b1;
				state_n   = ST_WAIT_M;
			end
			ST_WAIT_M: begin
				if (!sts.div_busy) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (last) begin
					state_n = ST_FIN;
				end else begin
					idx_n   = idx_q + 1'b1;
					state_n = ST_DIV_D;
				end
			end
			ST_FIN: begin
				cmd.fin      = 1'b1;
				cmd.out_load = 1'b1;
				state_n      = ST_IN;
			end
			default: begin
				state_n = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

	assign idx = idx_q;

endmodule

[src/knock_rhythm_matcher.sv]
// ----------------------------------------------------------------------------
// knock_rhythm_matcher: knock rhythm lock
// Detects knocks in a sample stream, times the gaps between them and, once
// a full pattern is captured, compares its normalized shape with the
// configured one; a match opens the lock for a hold time.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one sample per tick
//  m_*     | out | m_tvalid/m_tready  | one result per sample
//  cfg_*   | in  | cfg_valid/cfg_ready| register write, always ready
//
//  A sample passes through an accept and a tick step. A sample that closes
//  a pattern then runs one sum step per entry, then per entry two divider
//  runs (start, busy, a step to see it done) plus a tolerance check. The
//  divider is the one shared long-latency unit. The next sample is accepted
//  while the previous result still waits; the tick stalls only if that
//  result is still not taken.
//  Reset clears config to defaults and the block to waiting for a first
//  knock; no clearing pass is needed.
// ----------------------------------------------------------------------------
module knock_rhythm_matcher
	import krm_pkg::*;
#(
	parameter int PATTERN_LEN = 2,      // 1..4 intervals per pattern
	parameter int INTERVAL_BITS = 24    // 16..32, gap counter width
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample (signed)
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,    // [0] lock_open, [1] pattern_done,
	                                          // [2] matched, [7:3] zero
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

	krm_cmd_t         cmd;
	krm_sts_t         sts;
	logic [IDX_W-1:0] idx;

	// sequencing: tick, sums, divisions, check, outcome
	krm_ctrl #(
		.PATTERN_LEN (PATTERN_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	// registers, knock state, divider and result word
	krm_dp #(
		.PATTERN_LEN   (PATTERN_LEN),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.idx       (idx),
		.sts       (sts)
	);

endmodule
